[design/hbcd_pkg.sv]
// Shared types, constants and helpers for the HTTP body chunk deframer.
// Depends on nothing; the core takes these by scoped names.

package hbcd_pkg;

   // Default width of the size, chunk and body counters
   localparam int COUNT_BITS_DEF = 31;

   // Widths fixed by the beat fields and the register map
   localparam int BYTE_BITS   = 8;
   localparam int LEN_BITS    = 31;
   localparam int CSR_DW      = 32;
   localparam int CSR_AW      = 3;
   localparam int CMP_BITS    = 32;

   // Framing characters
   localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_SP = 8'h20;

   // Register indexes, taken from paddr[2]
   typedef enum logic {
      REG_CHUNKED_MODE   = 1'b0,
      REG_CONTENT_LENGTH = 1'b1
   } reg_idx_type;

   // Error codes carried on the result beat
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_CHAR = 2'd1,
      ERR_NO_CRLF  = 2'd2,
      ERR_SIZE_OVF = 2'd3
   } err_type;

   // Decoder phases; the error phases hold the sticky error
   typedef enum logic [7:0] {
      PH_SIZE     = 8'b0000_0001,
      PH_SIZE_LF  = 8'b0000_0010,
      PH_DATA     = 8'b0000_0100,
      PH_DATA_CR  = 8'b0000_1000,
      PH_DATA_LF  = 8'b0001_0000,
      PH_ERR_CHAR = 8'b0010_0000,
      PH_ERR_CRLF = 8'b0100_0000,
      PH_ERR_OVF  = 8'b1000_0000
   } phase_type;

   // One result beat
   typedef struct packed {
      logic                 has_byte;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 body_end;
      logic [1:0]           error_code;
   } rsp_type;

   // Decode an ASCII hex digit: bit 4 marks a valid digit, bits 3:0 its value
   function automatic logic [4:0] hex_digit(input logic [BYTE_BITS-1:0] c);
      logic [4:0] r;
      r = 5'b0_0000;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

[design/http_body_chunk_deframer_core.sv]
// HTTP message body deframer core: chunked and content-length body decoding.
// Depends on hbcd_pkg for phases, error codes, the result struct and hex decode.
//
// A result beat is registered in the result queue before it appears on rsp_*.
// Throughput: one byte per cycle; each byte is a single state update in front of
// a two-slot result queue, and req_tready drops only while both slots are full.
// Reset (synchronous, active high) clears the decoder state, the counters, both
// registers and the result queue; the block takes bytes in the next cycle.

module http_body_chunk_deframer_core #(
   parameter int COUNT_BITS = hbcd_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Byte channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hbcd_pkg::BYTE_BITS-1:0] req_tdata,   // [7:0] byte_in
   // Result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hbcd_pkg::BYTE_BITS-1:0] rsp_tdata,   // [7:0] payload_byte
   output logic                          rsp_tlast,   // body_end
   output logic [2:0]                    rsp_tuser,   // [0] has_byte, [2:1] error_code
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hbcd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hbcd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hbcd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // Registers
   logic                               chunked_mode_ff;
   logic [hbcd_pkg::LEN_BITS-1:0]      content_length_ff;
   hbcd_pkg::phase_type                phase_ff, phase_in;
   logic [COUNT_BITS-1:0]              size_accum_ff, size_accum_in;
   logic [COUNT_BITS-1:0]              bytes_left_ff, bytes_left_in;
   logic [COUNT_BITS-1:0]              body_count_ff, body_count_in;
   logic                               finished_ff, finished_in;

   // Result queue: slot 0 is the head
   logic                               out0_valid_ff, out1_valid_ff;
   hbcd_pkg::rsp_type                  out0_ff, out1_ff;

   // Step signals
   logic                               accept;
   logic                               emit;
   hbcd_pkg::rsp_type                  res;
   logic [4:0]                         hex;
   logic [COUNT_BITS-1:0]              count_inc;
   logic [COUNT_BITS-1:0]              left_dec;
   logic                               len_reached;
   logic                               csr_write;
   logic                               pop;

   assign accept    = req_tvalid && req_tready;
   assign pop       = out0_valid_ff && rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register port
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (hbcd_pkg::reg_idx_type'(csr_paddr[2]))
         hbcd_pkg::REG_CHUNKED_MODE:
            csr_prdata = {{(hbcd_pkg::CSR_DW-1){1'b0}}, chunked_mode_ff};
         hbcd_pkg::REG_CONTENT_LENGTH:
            csr_prdata = {{(hbcd_pkg::CSR_DW-hbcd_pkg::LEN_BITS){1'b0}}, content_length_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         content_length_ff <= '0;
      end else if (csr_write) begin
         unique case (hbcd_pkg::reg_idx_type'(csr_paddr[2]))
            hbcd_pkg::REG_CHUNKED_MODE:   chunked_mode_ff   <= csr_pwdata[0];
            hbcd_pkg::REG_CONTENT_LENGTH: content_length_ff <= csr_pwdata[hbcd_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Decode one byte against the current state
   assign hex         = hbcd_pkg::hex_digit(req_tdata);
   assign count_inc   = (body_count_ff != CNT_MAX) ? body_count_ff + 1'b1 : body_count_ff;
   assign left_dec    = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;
   assign len_reached = (content_length_ff != '0) &&
                        (hbcd_pkg::CMP_BITS'(count_inc) >=
                         hbcd_pkg::CMP_BITS'(content_length_ff));

   always_comb begin
      phase_in      = phase_ff;
      size_accum_in = size_accum_ff;
      bytes_left_in = bytes_left_ff;
      body_count_in = body_count_ff;
      finished_in   = finished_ff;
      emit          = 1'b0;
      res           = '0;

      unique case (phase_ff)
         // Sticky errors: report on every byte
         hbcd_pkg::PH_ERR_CHAR: begin
            emit           = 1'b1;
            res.error_code = hbcd_pkg::ERR_BAD_CHAR;
         end
         hbcd_pkg::PH_ERR_CRLF: begin
            emit           = 1'b1;
            res.error_code = hbcd_pkg::ERR_NO_CRLF;
         end
         hbcd_pkg::PH_ERR_OVF: begin
            emit           = 1'b1;
            res.error_code = hbcd_pkg::ERR_SIZE_OVF;
         end
         default: begin
            if (finished_ff) begin
               // body is over: drop the byte
            end else if (!chunked_mode_ff) begin
               // Length mode: pass the byte, count it, end at the length if it is nonzero
               body_count_in    = count_inc;
               emit             = 1'b1;
               res.has_byte     = 1'b1;
               res.payload_byte = req_tdata;
               res.body_end     = len_reached;
               finished_in      = len_reached;
            end else begin
               unique case (phase_ff)
                  hbcd_pkg::PH_SIZE: begin
                     if (req_tdata == hbcd_pkg::CHAR_SP) begin
                        // skip
                     end else if (req_tdata == hbcd_pkg::CHAR_CR) begin
                        phase_in = hbcd_pkg::PH_SIZE_LF;
                     end else if (!hex[4]) begin
                        phase_in       = hbcd_pkg::PH_ERR_CHAR;
                        emit           = 1'b1;
                        res.error_code = hbcd_pkg::ERR_BAD_CHAR;
                     end else if (size_accum_ff[COUNT_BITS-1 -: 4] != 4'h0) begin
                        phase_in       = hbcd_pkg::PH_ERR_OVF;
                        emit           = 1'b1;
                        res.error_code = hbcd_pkg::ERR_SIZE_OVF;
                     end else begin
                        size_accum_in = {size_accum_ff[COUNT_BITS-5:0], hex[3:0]};
                     end
                  end
                  hbcd_pkg::PH_SIZE_LF: begin
                     if (req_tdata != hbcd_pkg::CHAR_LF) begin
                        phase_in       = hbcd_pkg::PH_ERR_CHAR;
                        emit           = 1'b1;
                        res.error_code = hbcd_pkg::ERR_BAD_CHAR;
                     end else if (size_accum_ff == '0) begin
                        // last chunk: end the body
                        finished_in  = 1'b1;
                        phase_in     = hbcd_pkg::PH_SIZE;
                        emit         = 1'b1;
                        res.body_end = 1'b1;
                     end else begin
                        bytes_left_in = size_accum_ff;
                        size_accum_in = '0;
                        phase_in      = hbcd_pkg::PH_DATA;
                     end
                  end
                  hbcd_pkg::PH_DATA: begin
                     bytes_left_in    = left_dec;
                     if (left_dec == '0) begin
                        phase_in = hbcd_pkg::PH_DATA_CR;
                     end
                     emit             = 1'b1;
                     res.has_byte     = 1'b1;
                     res.payload_byte = req_tdata;
                  end
                  hbcd_pkg::PH_DATA_CR: begin
                     if (req_tdata != hbcd_pkg::CHAR_CR) begin
                        phase_in       = hbcd_pkg::PH_ERR_CRLF;
                        emit           = 1'b1;
                        res.error_code = hbcd_pkg::ERR_NO_CRLF;
                     end else begin
                        phase_in = hbcd_pkg::PH_DATA_LF;
                     end
                  end
                  default: begin
                     // trailing LF of the chunk
                     if (req_tdata != hbcd_pkg::CHAR_LF) begin
                        phase_in       = hbcd_pkg::PH_ERR_CRLF;
                        emit           = 1'b1;
                        res.error_code = hbcd_pkg::ERR_NO_CRLF;
                     end else begin
                        phase_in = hbcd_pkg::PH_SIZE;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // Advance decoder state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hbcd_pkg::PH_SIZE;
         size_accum_ff <= '0;
         bytes_left_ff <= '0;
         body_count_ff <= '0;
         finished_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         size_accum_ff <= size_accum_in;
         bytes_left_ff <= bytes_left_in;
         body_count_ff <= body_count_in;
         finished_ff   <= finished_in;
      end
   end

   // Result queue: take a new byte while slot 1 is free, even while one beat waits downstream
   assign req_tready = !out1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out0_valid_ff <= 1'b0;
         out1_valid_ff <= 1'b0;
      end else if (pop) begin
         if (out1_valid_ff) begin
            out1_valid_ff <= accept && emit;
         end else begin
            out0_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         if (out0_valid_ff) begin
            out1_valid_ff <= 1'b1;
         end else begin
            out0_valid_ff <= 1'b1;
         end
      end
   end

   // Hold queued beats; a pop shifts slot 1 to the head, else a free slot takes the new result
   always_ff @(posedge clock) begin
      if (pop) begin
         if (out1_valid_ff) begin
            out0_ff <= out1_ff;
            out1_ff <= res;
         end else begin
            out0_ff <= res;
         end
      end else if (accept && emit) begin
         if (out0_valid_ff) begin
            out1_ff <= res;
         end else begin
            out0_ff <= res;
         end
      end
   end

   assign rsp_tvalid = out0_valid_ff;
   assign rsp_tdata  = out0_ff.payload_byte;
   assign rsp_tlast  = out0_ff.body_end;
   assign rsp_tuser  = {out0_ff.error_code, out0_ff.has_byte};

   // Checks
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      out1_valid_ff |-> out0_valid_ff)
      else $error("result slot 1 full while head is empty");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hbcd_pkg::PH_ERR_CHAR || phase_ff == hbcd_pkg::PH_ERR_CRLF ||
       phase_ff == hbcd_pkg::PH_ERR_OVF) |=> $stable(phase_ff))
      else $error("error phase left before reset");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] != hbcd_pkg::ERR_NONE) |->
      (!rsp_tuser[0] && !rsp_tlast))
      else $error("error beat carries data or end mark");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("end of body cleared before reset");

endmodule
